### design/ofir_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofir_pkg: shared definitions for the overlap-add block FIR
// Sizes, input codes and the control structs that pass between the
// top level, the tap chain and its cells.
// ---------------------------------------------------------------------------
package ofir_pkg;

    // block and filter sizes
    localparam int BLOCK_LEN = 128;
    localparam int MAX_TAPS  = 128;
    localparam int HIST_LEN  = 2 * BLOCK_LEN;

    // field widths
    localparam int SMP_W     = 16;
    localparam int TAP_IDX_W = 7;
    localparam int FRAC_BITS = 15;

    // derived widths
    localparam int POS_W      = $clog2(BLOCK_LEN);
    localparam int HADDR_W    = $clog2(HIST_LEN);
    localparam int TAP_CMP_W  = TAP_IDX_W + 1;
    localparam int PROD_W     = 2 * SMP_W;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS + 1);

    // saturation limits at accumulator width
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32'sd32767);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32'sd32768);

    // input word kinds
    localparam logic ACT_TAP    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COMPUTE,
        ST_DRAIN
    } state_t;

    // per-cycle control shared by every cell
    typedef struct packed {
        logic clr;
        logic en;
    } cell_ctl_t;

    // tap write request
    typedef struct packed {
        logic                        we;
        logic [TAP_IDX_W-1:0]        idx;
        logic signed [SMP_W-1:0]     value;
    } tap_wr_t;

endpackage

### design/ofir_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofir_cell: one tap of the transposed FIR chain
// Holds one filter tap and one partial sum. Each enabled cycle it adds
// tap * x to the partial sum handed over by its right neighbor.
// ---------------------------------------------------------------------------
module ofir_cell
    import ofir_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_ctl_t               ctl,
    input  logic                    tap_we,
    input  logic signed [SMP_W-1:0] tap_value,
    input  logic signed [SMP_W-1:0] x_in,
    input  logic signed [ACC_W-1:0] p_in,
    output logic signed [ACC_W-1:0] p_out
);

    logic signed [SMP_W-1:0]  tap_reg;
    logic signed [ACC_W-1:0]  p_reg;
    logic signed [ACC_W-1:0]  p_next;
    logic signed [PROD_W-1:0] prod;

    // store the tap; taps start at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
        end else if (tap_we) begin
            tap_reg <= tap_value;
        end
    end

    // multiply-accumulate onto the neighbor's partial sum
    always_comb begin
        prod = tap_reg * x_in;
        if (ctl.clr) begin
            p_next = '0;
        end else if (ctl.en) begin
            p_next = ACC_W'(prod) + p_in;
        end else begin
            p_next = p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p_out = p_reg;

endmodule

### design/ofir_chain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofir_chain: row of tap cells
// Decodes tap writes to their cell and links the partial sums from the
// highest tap down to tap zero, whose sum is the filter output.
// ---------------------------------------------------------------------------
module ofir_chain
    import ofir_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_ctl_t               ctl,
    input  tap_wr_t                 tap_wr,
    input  logic signed [SMP_W-1:0] x_in,
    output logic signed [ACC_W-1:0] y_out
);

    logic signed [ACC_W-1:0] p_link [MAX_TAPS+1];
    logic [MAX_TAPS-1:0]     tap_we;

    // nothing enters past the last tap
    assign p_link[MAX_TAPS] = '0;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        // select this cell for a tap write; larger indexes match no cell
        assign tap_we[k] = tap_wr.we
                        && (TAP_CMP_W'(tap_wr.idx) == TAP_CMP_W'(k));

        ofir_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .tap_we    (tap_we[k]),
            .tap_value (tap_wr.value),
            .x_in      (x_in),
            .p_in      (p_link[k+1]),
            .p_out     (p_link[k])
        );
    end

    assign y_out = p_link[0];

endmodule

### design/overlap_add_block_fir.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overlap_add_block_fir: block FIR with one block of delay
// Collects samples into blocks, filters each finished block through a
// chain of tap cells and plays the results out during the next block.
// ---------------------------------------------------------------------------
// A tap word does not hold off the next word. A sample word holds off the
// next word until its result is fetched from the output store and moved to
// the output register, which waits while that register holds an untaken
// word. A block's last sample word is followed by a pass in which s_ready is
// low: the sample history, on its single read port, streams the previous and
// the current block past the row of MAX_TAPS multiply-accumulate cells, one
// sample a cycle, and the block's outputs are written back to the output
// store. Each sample word returns the output for the same position of the
// previous block, so the first block returns zeros. Taps written during a
// block apply to the whole of that block when it completes.
// ---------------------------------------------------------------------------
module overlap_add_block_fir
    import ofir_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [TAP_IDX_W-1:0]        s_tap_index,
    input  logic signed [SMP_W-1:0]     s_tap_value,
    input  logic signed [SMP_W-1:0]     s_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SMP_W-1:0]     m_out_sample
);

    state_t state_reg, state_next;

    logic [POS_W-1:0]        pos_reg;
    logic                    half_reg;
    logic                    first_reg;

    logic                    pend_reg;
    logic                    pend_zero_reg;
    logic signed [SMP_W-1:0] out_rd_reg;
    logic                    m_valid_reg;
    logic signed [SMP_W-1:0] m_out_sample_reg;

    logic [POS_W-1:0]        cidx_reg;
    logic                    cphase_reg;

    logic signed [SMP_W-1:0] hist_q_reg;
    logic                    s1_v_reg;
    logic                    s1_cur_reg;
    logic                    s1_zero_reg;
    logic [POS_W-1:0]        s1_i_reg;
    logic                    s2_v_reg;
    logic                    s2_cur_reg;
    logic [POS_W-1:0]        s2_i_reg;

    logic signed [SMP_W-1:0] hist_mem [HIST_LEN];
    logic signed [SMP_W-1:0] out_mem  [BLOCK_LEN];

    logic                    in_fire;
    logic                    sample_fire;
    logic                    block_done;
    logic                    issue;
    logic                    clr;
    logic                    pend_move;
    logic                    out_we;
    logic [HADDR_W-1:0]      hist_waddr;
    logic [HADDR_W-1:0]      hist_raddr;
    logic                    rd_half;
    logic                    last_issue;

    logic signed [SMP_W-1:0] x_in;
    logic signed [ACC_W-1:0] y_acc;
    logic signed [ACC_W-1:0] y_shift;
    logic signed [SMP_W-1:0] y_sat;

    cell_ctl_t               cell_ctl;
    tap_wr_t                 tap_wr;

    assign in_fire     = s_valid && s_ready;
    assign sample_fire = in_fire && (s_action == ACT_SAMPLE);
    assign block_done  = sample_fire && (pos_reg == POS_W'(BLOCK_LEN - 1));
    assign last_issue  = cphase_reg && (cidx_reg == POS_W'(BLOCK_LEN - 1));
    assign pend_move   = pend_reg && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (block_done) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                state_next = ST_COMPUTE;
            end
            ST_COMPUTE: begin
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!s1_v_reg && !s2_v_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready = 1'b0;
        issue   = 1'b0;
        clr     = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready = !pend_reg;
            ST_CLEAR:   clr     = 1'b1;
            ST_COMPUTE: issue   = 1'b1;
            ST_DRAIN:   ;
            default:    ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // advance the block position; swap halves once a block is filtered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            half_reg  <= 1'b0;
            first_reg <= 1'b1;
        end else begin
            if (sample_fire) begin
                pos_reg <= block_done ? '0 : pos_reg + POS_W'(1);
            end
            if (state_reg == ST_DRAIN && state_next == ST_IDLE) begin
                half_reg  <= ~half_reg;
                first_reg <= 1'b0;
            end
        end
    end

    // store incoming samples into the current half of the history
    assign hist_waddr = half_reg ? HADDR_W'(BLOCK_LEN) + HADDR_W'(pos_reg)
                                 : HADDR_W'(pos_reg);

    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            hist_mem[hist_waddr] <= s_sample;
        end
    end

    // step through previous block, then current block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cidx_reg   <= '0;
            cphase_reg <= 1'b0;
        end else if (clr) begin
            cidx_reg   <= '0;
            cphase_reg <= 1'b0;
        end else if (issue) begin
            if (cidx_reg == POS_W'(BLOCK_LEN - 1)) begin
                cidx_reg   <= '0;
                cphase_reg <= ~cphase_reg;
            end else begin
                cidx_reg <= cidx_reg + POS_W'(1);
            end
        end
    end

    assign rd_half    = cphase_reg ? half_reg : ~half_reg;
    assign hist_raddr = rd_half ? HADDR_W'(BLOCK_LEN) + HADDR_W'(cidx_reg)
                                : HADDR_W'(cidx_reg);

    always_ff @(posedge aclk) begin
        if (issue) begin
            hist_q_reg <= hist_mem[hist_raddr];
        end
    end

    // track each history read as it moves toward the chain output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_cur_reg  <= cphase_reg;
        s1_zero_reg <= first_reg && !cphase_reg;
        s1_i_reg    <= cidx_reg;
        s2_cur_reg  <= s1_cur_reg;
        s2_i_reg    <= s1_i_reg;
    end

    // the half before the first block was never filled: feed zeros
    assign x_in = s1_zero_reg ? '0 : hist_q_reg;

    assign cell_ctl.clr = clr;
    assign cell_ctl.en  = s1_v_reg;

    // tap words go straight into the cells
    assign tap_wr.we    = in_fire && (s_action == ACT_TAP);
    assign tap_wr.idx   = s_tap_index;
    assign tap_wr.value = s_tap_value;

    ofir_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cell_ctl),
        .tap_wr  (tap_wr),
        .x_in    (x_in),
        .y_out   (y_acc)
    );

    // drop the fraction bits (floor) and saturate to 16 bits
    always_comb begin
        y_shift = y_acc >>> FRAC_BITS;
        if (y_shift > Q_MAX) begin
            y_sat = Q_MAX[SMP_W-1:0];
        end else if (y_shift < Q_MIN) begin
            y_sat = Q_MIN[SMP_W-1:0];
        end else begin
            y_sat = y_shift[SMP_W-1:0];
        end
    end

    // write back outputs of the current block only
    assign out_we = s2_v_reg && s2_cur_reg;

    always_ff @(posedge aclk) begin
        if (out_we) begin
            out_mem[s2_i_reg] <= y_sat;
        end
    end

    // fetch the stored output for this sample position
    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            out_rd_reg    <= out_mem[pos_reg];
            pend_zero_reg <= first_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (sample_fire) begin
            pend_reg <= 1'b1;
        end else if (pend_move) begin
            pend_reg <= 1'b0;
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pend_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_move) begin
            m_out_sample_reg <= pend_zero_reg ? '0 : out_rd_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_out_sample_reg;

    // a completed block always starts the filter pass
    a_block_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        block_done |=> state_reg == ST_CLEAR)
        else $error("completed block did not start the filter pass");

    // output store is written only while a block is being filtered
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        out_we |-> (state_reg == ST_COMPUTE || state_reg == ST_DRAIN))
        else $error("output store written outside the filter pass");

    // every accepted sample leaves a result in flight
    a_sample_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_fire |=> pend_reg)
        else $error("accepted sample produced no pending result");

    // no word is accepted while a result is still being fetched
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !in_fire)
        else $error("word accepted while a result was pending");

endmodule

### test/overlap_add_block_fir_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overlap_add_block_fir_tb: self-checking bench for the block FIR
// Drives tap and sample words with random pacing on both channels and
// convolves each finished block in a local predictor. Every result word is
// compared in order with the predicted output of the previous block.
// ---------------------------------------------------------------------------
module overlap_add_block_fir_tb;
    import ofir_pkg::*;

    localparam int WORD_TARGET    = 1350;
    localparam int TAIL_WORDS     = 250;
    localparam int SETTLE_CYCLES  = 300;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;

    // -----------------------------------------------------------------------
    // Predictor and result checker
    // -----------------------------------------------------------------------
    class fir_out_checker;
        logic signed [SMP_W-1:0] taps [MAX_TAPS];
        logic signed [SMP_W-1:0] history [HIST_LEN];
        logic signed [SMP_W-1:0] block_out [BLOCK_LEN];
        int unsigned             fill_pos;
        bit                      fill_half;
        logic signed [SMP_W-1:0] expected_out [$];
        int n_tap_words, n_sample_words, n_checked, n_blocks, n_clipped, n_fail;

        function new();
            foreach (taps[i]) taps[i] = '0;
            foreach (history[i]) history[i] = '0;
            foreach (block_out[i]) block_out[i] = '0;
            fill_pos  = 0;
            fill_half = 1'b0;
        endfunction

        // convolve the block just filled with the current taps
        function void filter_block();
            int unsigned base, i, j, idx;
            longint      acc, q;
            base = fill_half ? BLOCK_LEN : 0;
            for (i = 0; i < BLOCK_LEN; i++) begin
                acc = 0;
                for (j = 0; j < MAX_TAPS && j <= i + BLOCK_LEN; j++) begin
                    idx = (base + i + HIST_LEN - j) % HIST_LEN;
                    acc += longint'(taps[j]) * longint'(history[idx]);
                end
                // floor shift, then clip to int16
                q = acc >>> FRAC_BITS;
                if (q > 32767) begin
                    q = 32767;
                    n_clipped++;
                end else if (q < -32768) begin
                    q = -32768;
                    n_clipped++;
                end
                block_out[i] = SMP_W'(q);
            end
            n_blocks++;
        endfunction

        // update state for one accepted input word
        function void note_word(logic act, logic [TAP_IDX_W-1:0] idx,
                                logic signed [SMP_W-1:0] tap_val,
                                logic signed [SMP_W-1:0] smp);
            if (act == ACT_TAP) begin
                if (idx < MAX_TAPS)
                    taps[idx] = tap_val;
                n_tap_words++;
            end else begin
                expected_out.push_back(block_out[fill_pos]);
                history[(fill_half ? BLOCK_LEN : 0) + fill_pos] = smp;
                fill_pos++;
                if (fill_pos == BLOCK_LEN) begin
                    filter_block();
                    fill_pos  = 0;
                    fill_half = !fill_half;
                end
                n_sample_words++;
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_out(logic signed [SMP_W-1:0] got);
            logic signed [SMP_W-1:0] want;
            if (expected_out.size() == 0) begin
                $error("out_sample: no result expected, actual %0d", got);
                n_fail++;
            end else begin
                want = expected_out.pop_front();
                n_checked++;
                if (got !== want) begin
                    $error("out_sample mismatch: expected %0d, actual %0d", want, got);
                    n_fail++;
                end
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_action;
    logic [TAP_IDX_W-1:0]    s_tap_index;
    logic signed [SMP_W-1:0] s_tap_value;
    logic signed [SMP_W-1:0] s_sample;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [SMP_W-1:0] m_out_sample;

    fir_out_checker chk = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_req;
    int n_words;

    overlap_add_block_fir u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_tap_index  (s_tap_index),
        .s_tap_value  (s_tap_value),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // accept result words and pace m_ready
    initial begin
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                chk.check_out(m_out_sample);
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold == 0 && rx_idle_pct > 0 &&
                         $urandom_range(0, 99) < rx_idle_pct) begin
                hold = $urandom_range(1, 19);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // end the run if no word moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // offer one word, hold it until accepted, then maybe pause
    task automatic send_word(input logic act, input logic [TAP_IDX_W-1:0] idx,
                             input logic signed [SMP_W-1:0] tap_val,
                             input logic signed [SMP_W-1:0] smp);
        s_valid     <= 1'b1;
        s_action    <= act;
        s_tap_index <= idx;
        s_tap_value <= tap_val;
        s_sample    <= smp;
        do @(posedge aclk); while (!s_ready);
        chk.note_word(act, idx, tap_val, smp);
        n_words++;
        // run the tail of the test at full rate on both sides
        if (n_words >= WORD_TARGET - TAIL_WORDS) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_tap(input int idx, input logic signed [SMP_W-1:0] val);
        send_word(ACT_TAP, TAP_IDX_W'(idx), val, SMP_W'($urandom));
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] val);
        send_word(ACT_SAMPLE, TAP_IDX_W'($urandom), SMP_W'($urandom), val);
    endtask

    task automatic clear_taps();
        int t;
        for (t = 0; t < MAX_TAPS; t++)
            send_tap(t, '0);
    endtask

    // stop offering until every expected result has come back
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk.expected_out.size() != 0);
    endtask

    function automatic logic signed [SMP_W-1:0] small_value();
        return SMP_W'(int'($urandom_range(0, 2048)) - 1024);
    endfunction

    function automatic logic signed [SMP_W-1:0] audio_value();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1, 2, 3: return small_value();
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        int phase, n, k;
        s_valid       <= 1'b0;
        s_action      <= ACT_TAP;
        s_tap_index   <= '0;
        s_tap_value   <= '0;
        s_sample      <= '0;
        aresetn       <= 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        long_hold_req = 1'b0;
        n_words       = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extreme taps and samples, a tap overwrite, a mid-block write;
        // a full-scale tap pair drives the sum past both clip limits
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        send_tap(0, S_MAX);
        send_tap(MAX_TAPS - 1, S_MIN);
        send_tap(1, S_MIN);
        send_tap(64, 1);
        send_tap(64, 0);
        send_tap(2, -1);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_tap(3, 16384);
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MIN);

        // random phases with different tap profiles
        phase = 1;
        while (n_words < WORD_TARGET) begin
            if (n_words >= WORD_TARGET - TAIL_WORDS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = (phase == 3) ? 0 : 12;
                rx_idle_pct = (phase == 4) ? 0 : 12;
            end
            case (phase % 4)
                0: begin
                    clear_taps();
                    repeat ($urandom_range(1, 4))
                        send_tap($urandom_range(0, MAX_TAPS - 1), SMP_W'($urandom));
                end
                1: begin
                    repeat ($urandom_range(8, 24))
                        send_tap($urandom_range(0, MAX_TAPS - 1), small_value());
                end
                2: begin
                    repeat ($urandom_range(4, 12))
                        send_tap($urandom_range(0, MAX_TAPS - 1), SMP_W'($urandom));
                end
                default: begin
                    clear_taps();
                    for (k = 0; k < 32; k++)
                        send_tap(k, small_value());
                end
            endcase
            // hold off the receiver so the block backs up into its input
            if (phase == 2)
                long_hold_req = 1'b1;
            n = $urandom_range(BLOCK_LEN, 2 * BLOCK_LEN);
            repeat (n) begin
                if (n_words >= WORD_TARGET)
                    break;
                if ($urandom_range(0, 99) < 4)
                    send_tap($urandom_range(0, MAX_TAPS - 1), small_value());
                else
                    send_sample(audio_value());
            end
            if (phase == 3)
                wait_results();
            phase++;
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d tap words and %0d sample words over %0d filtered blocks.",
                 chk.n_tap_words, chk.n_sample_words, chk.n_blocks);
        $display("Checked %0d results, %0d clipped in prediction, %0d failures.",
                 chk.n_checked, chk.n_clipped, chk.n_fail);
        if (chk.n_fail == 0 && chk.expected_out.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
